/* rtl/core/mfde_pkg.sv */
// Package: display geometry, request codes and the glyph font for the draw engine.
package mfde_pkg;
   localparam int DispWidth  = 128;
   localparam int DispHeight = 64;
   localparam int FbPages    = (DispHeight + 7) / 8;
   localparam int FbBytes    = DispWidth * FbPages;
   localparam int AddrW      = $clog2(FbBytes);
   localparam int PageW      = (FbPages > 1) ? $clog2(FbPages) : 1;

   localparam logic [3:0] REQ_PIXEL  = 4'd0;
   localparam logic [3:0] REQ_HSPAN  = 4'd1;
   localparam logic [3:0] REQ_VSPAN  = 4'd2;
   localparam logic [3:0] REQ_RECT   = 4'd3;
   localparam logic [3:0] REQ_FILL   = 4'd4;
   localparam logic [3:0] REQ_GLYPH  = 4'd5;
   localparam logic [3:0] REQ_CLEAR  = 4'd6;
   localparam logic [3:0] REQ_INVERT = 4'd7;
   localparam logic [3:0] REQ_READ   = 4'd8;

   localparam logic [7:0] GlyphFirst = 8'd32;
   localparam logic [7:0] GlyphLast  = 8'd126;

   function automatic logic [39:0] glyph_row(input logic [6:0] idx);
      logic [39:0] r;
      unique case (idx)
         7'd0: r=40'h0000000000; 7'd1: r=40'h00005F0000; 7'd2: r=40'h0007000700;
         7'd3: r=40'h147F147F14; 7'd4: r=40'h242A7F2A12; 7'd5: r=40'h2313086462;
         7'd6: r=40'h3649552250; 7'd7: r=40'h0005030000; 7'd8: r=40'h001C224100;
         7'd9: r=40'h0041221C00; 7'd10: r=40'h14083E0814; 7'd11: r=40'h08083E0808;
         7'd12: r=40'h0050300000; 7'd13: r=40'h0808080808; 7'd14: r=40'h0060600000;
         7'd15: r=40'h2010080402; 7'd16: r=40'h3E5149453E; 7'd17: r=40'h00427F4000;
         7'd18: r=40'h4261514946; 7'd19: r=40'h2141454B31; 7'd20: r=40'h1814127F10;
         7'd21: r=40'h2745454539; 7'd22: r=40'h3C4A494931; 7'd23: r=40'h4121110907;
         7'd24: r=40'h3649494936; 7'd25: r=40'h464949291E; 7'd26: r=40'h0036360000;
         7'd27: r=40'h0056360000; 7'd28: r=40'h0814224100; 7'd29: r=40'h1414141414;
         7'd30: r=40'h0041221408; 7'd31: r=40'h0201510906; 7'd32: r=40'h324959513E;
         7'd33: r=40'h7E1111117E; 7'd34: r=40'h7F49494936; 7'd35: r=40'h3E41414122;
         7'd36: r=40'h7F4141413E; 7'd37: r=40'h7F49494941; 7'd38: r=40'h7F09090901;
         7'd39: r=40'h3E4149497A; 7'd40: r=40'h7F0808087F; 7'd41: r=40'h00417F4100;
         7'd42: r=40'h2040413F01; 7'd43: r=40'h7F08142241; 7'd44: r=40'h7F40404040;
         7'd45: r=40'h7F020C027F; 7'd46: r=40'h7F0408107F; 7'd47: r=40'h3E4141413E;
         7'd48: r=40'h7F09090906; 7'd49: r=40'h3E4151215E; 7'd50: r=40'h7F09192946;
         7'd51: r=40'h4649494931; 7'd52: r=40'h01017F0101; 7'd53: r=40'h3F4040403F;
         7'd54: r=40'h1F2040201F; 7'd55: r=40'h3F4038403F; 7'd56: r=40'h6314081463;
         7'd57: r=40'h0708700807; 7'd58: r=40'h6151494543; 7'd59: r=40'h007F414100;
         7'd60: r=40'h0204081020; 7'd61: r=40'h0041417F00; 7'd62: r=40'h0402010204;
         7'd63: r=40'h4040404040; 7'd64: r=40'h0003070000; 7'd65: r=40'h2054545478;
         7'd66: r=40'h7F48444438; 7'd67: r=40'h3844444420; 7'd68: r=40'h384444487F;
         7'd69: r=40'h3854545418; 7'd70: r=40'h087E090102; 7'd71: r=40'h0C5252523E;
         7'd72: r=40'h7F08040478; 7'd73: r=40'h00447D4000; 7'd74: r=40'h2040443D00;
         7'd75: r=40'h7F10284400; 7'd76: r=40'h00417F4000; 7'd77: r=40'h7C04180478;
         7'd78: r=40'h7C08040478; 7'd79: r=40'h3844444438; 7'd80: r=40'h7C14141408;
         7'd81: r=40'h081414187C; 7'd82: r=40'h7C08040408; 7'd83: r=40'h4854545420;
         7'd84: r=40'h043F444020; 7'd85: r=40'h3C4040207C; 7'd86: r=40'h1C2040201C;
         7'd87: r=40'h3C4030403C; 7'd88: r=40'h4428102844; 7'd89: r=40'h0C5050503C;
         7'd90: r=40'h4464544C44; 7'd91: r=40'h0008364100; 7'd92: r=40'h00007F0000;
         7'd93: r=40'h0041360800; 7'd94: r=40'h1008080810;
         default: r = 40'h0;
      endcase
      return r;
   endfunction
endpackage

/* rtl/core/mono_framebuffer_draw_engine_unit.sv */
// Top level: page-organized monochrome framebuffer with a byte-walking draw sequencer.
//
// Every request becomes a list of byte operations on the framebuffer memory
// (AND mask, OR mask, XOR, or read). A sequencer walks the operations one at a
// time through the single-port frame store: read in state RD, modify and write
// in state WR. Whole-buffer sweeps (clear, invert) go byte by byte through RD
// and WR; pixel-wise walks add a step state (NEXT) before each pixel. A pixel
// request does one read-modify-write and a read request one read; an hspan
// walks its columns, a vspan its rows, a rectangle outline its four spans in
// turn, a fill the columns of each row; a glyph writes each set font pixel and
// steps over empty slots (5x7 slots); clear and invert touch every byte of the
// buffer. After reset a clearing pass zeroes the store, one byte a cycle, while
// no request is accepted. One request is in flight at a time; the response
// sits in an output register and the next request is taken once it has been
// delivered.
module mono_framebuffer_draw_engine_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // req_tuser: req_type[3:0]
   input  logic [3:0]  req_tuser,
   // req_tdata: pos_x[7:0] pos_y[15:8] extent_a[23:16] extent_b[31:24]
   //            color[32] char_code[40:33] byte_index[50:41], zero pad to 56
   input  logic [55:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // rsp_tdata: read_data[7:0] status[8], zero pad to 16
   output logic [15:0] rsp_tdata
);
   import mfde_pkg::*;

   localparam logic [2:0] ST_INIT  = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_RD    = 3'd2;
   localparam logic [2:0] ST_WR    = 3'd3;
   localparam logic [2:0] ST_NEXT  = 3'd4;
   localparam logic [2:0] ST_RESP  = 3'd5;

   // span phase of a request: up to four spans (rect) or many rows (fill)
   logic [2:0]  state_ff, state_in;
   logic [3:0]  kind_ff, kind_in;
   logic [7:0]  px_ff, px_in, py_ff, py_in, xe_ff, xe_in, ye_ff, ye_in;
   logic [8:0]  yend_ff, yend_in;     // fill row limit, no wrap
   logic        color_ff, color_in;
   logic [6:0]  gidx_ff, gidx_in;
   logic [1:0]  edge_ff, edge_in;     // rect edge counter
   // current walk: horizontal runs x over [cx..lim] at row cy; vertical runs y
   logic [8:0]  cx_ff, cx_in, cy_ff, cy_in;
   logic [8:0]  lim_ff, lim_in;
   logic        vert_ff, vert_in;
   logic [2:0]  gc_ff, gc_in, gr_ff, gr_in;
   logic [AddrW:0] ca_ff, ca_in;      // whole-buffer sweep address / init count
   logic [7:0]  rd_ff, rd_in;
   logic        st_ff, st_in;
   logic        rv_ff, rv_in;

   logic [7:0]  mem [FbBytes];
   logic [7:0]  q_ff;
   logic        we;
   logic [AddrW-1:0] addr;
   logic [7:0]  wdata;

   logic [3:0]  rtype;
   logic [7:0]  ipx, ipy, iea, ieb, icode;
   logic        icolor;
   logic [9:0]  ibidx;
   assign rtype  = req_tuser;
   assign ipx    = req_tdata[7:0];
   assign ipy    = req_tdata[15:8];
   assign iea    = req_tdata[23:16];
   assign ieb    = req_tdata[31:24];
   assign icolor = req_tdata[32];
   assign icode  = req_tdata[40:33];
   assign ibidx  = req_tdata[50:41];

   logic        sweep;   // clear / invert / read walk by linear address
   assign sweep = (kind_ff == REQ_CLEAR) || (kind_ff == REQ_INVERT) ||
                  (kind_ff == REQ_READ);

   // current pixel
   logic [8:0]  pxx, pxy;
   logic [39:0] gbits;
   logic        gbit;
   assign gbits = glyph_row(gidx_ff);
   always_comb begin
      gbit = gbits[6'(32 - 8 * int'(gc_ff) + int'(gr_ff))];
   end
   always_comb begin
      if (kind_ff == REQ_GLYPH) begin
         pxx = 9'(px_ff) + 9'(gc_ff);
         pxy = 9'(py_ff) + 9'(gr_ff);
      end else begin
         pxx = cx_ff;
         pxy = cy_ff;
      end
   end
   logic pix_ok;
   assign pix_ok = (pxx < 9'(DispWidth)) && (pxy < 9'(DispHeight)) &&
                   ((kind_ff != REQ_GLYPH) || gbit);

   always_comb begin
      if (state_ff == ST_INIT) addr = ca_ff[AddrW-1:0];
      else if (sweep) addr = ca_ff[AddrW-1:0];
      else addr = AddrW'(32'(pxy[8:3]) * DispWidth + 32'(pxx));
   end

   logic [7:0] mask;
   assign mask = 8'(1) << pxy[2:0];
   always_comb begin
      we = 1'b0;
      wdata = q_ff;
      if (state_ff == ST_INIT) begin
         we = 1'b1;
         wdata = 8'h00;
      end else if (state_ff == ST_WR) begin
         unique case (kind_ff)
            REQ_CLEAR:  begin we = 1'b1; wdata = 8'h00; end
            REQ_INVERT: begin we = 1'b1; wdata = q_ff ^ 8'hFF; end
            REQ_READ:   we = 1'b0;
            default:    begin
               we = 1'b1;
               wdata = color_ff ? (q_ff | mask) : (q_ff & ~mask);
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (we) mem[addr] <= wdata;
      q_ff <= mem[addr];
   end

   logic acc;
   assign req_tready = (state_ff == ST_IDLE) && !rv_ff;
   assign acc = req_tvalid && req_tready;
   assign rsp_tvalid = rv_ff;
   assign rsp_tdata = {7'd0, st_ff, rd_ff};

   // span setup: orders ends a,b; returns start (lower end), limit (higher end)
   function automatic logic [17:0] hsetup(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] lo, hi;
      lo = (a > b) ? b : a;
      hi = (a > b) ? a : b;
      return {9'(lo), 9'(hi)};
   endfunction

   always_comb begin
      state_in = state_ff; kind_in = kind_ff; px_in = px_ff; py_in = py_ff;
      xe_in = xe_ff; ye_in = ye_ff; yend_in = yend_ff; color_in = color_ff;
      gidx_in = gidx_ff; edge_in = edge_ff; cx_in = cx_ff; cy_in = cy_ff;
      lim_in = lim_ff; vert_in = vert_ff; gc_in = gc_ff; gr_in = gr_ff;
      ca_in = ca_ff; rd_in = rd_ff; st_in = st_ff; rv_in = rv_ff;
      if (rv_ff && rsp_tready) rv_in = 1'b0;
      unique case (state_ff)
         ST_INIT: begin
            ca_in = ca_ff + 1'b1;
            if (ca_ff == (AddrW+1)'(FbBytes - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (acc) begin
               kind_in = rtype; px_in = ipx; py_in = ipy; color_in = icolor;
               xe_in = ipx + iea - 8'd1; ye_in = ipy + ieb - 8'd1;
               yend_in = 9'(ipy) + 9'(ieb);
               gidx_in = 7'(icode - GlyphFirst);
               rd_in = 8'd0; st_in = 1'b0; ca_in = '0; edge_in = 2'd0;
               gc_in = 3'd0; gr_in = 3'd0;
               state_in = ST_NEXT;
               priority case (rtype)
                  REQ_PIXEL: begin
                     st_in = (9'(ipx) >= 9'(DispWidth)) || (9'(ipy) >= 9'(DispHeight));
                     cx_in = 9'(ipx); cy_in = 9'(ipy); lim_in = 9'(ipx); vert_in = 1'b0;
                     state_in = st_in ? ST_RESP : ST_RD;
                  end
                  REQ_HSPAN: begin
                     {cx_in, lim_in} = hsetup(ipx, iea); cy_in = 9'(ipy); vert_in = 1'b0;
                     st_in = 9'(ipy) >= 9'(DispHeight);
                     state_in = st_in ? ST_RESP : ST_NEXT;
                  end
                  REQ_VSPAN: begin
                     {cy_in, lim_in} = hsetup(ipy, ieb); cx_in = 9'(ipx); vert_in = 1'b1;
                     st_in = 9'(ipx) >= 9'(DispWidth);
                     state_in = st_in ? ST_RESP : ST_NEXT;
                  end
                  REQ_RECT: begin
                     // edge 0 loaded here; later edges loaded when a walk ends
                     {cx_in, lim_in} = hsetup(ipx, ipx + iea - 8'd1);
                     cy_in = 9'(ipy); vert_in = 1'b0;
                     if (9'(ipy) >= 9'(DispHeight)) lim_in = 9'h1FF;
                     if (9'(ipy) >= 9'(DispHeight)) cx_in = 9'h100;
                  end
                  REQ_FILL: begin
                     {cx_in, lim_in} = hsetup(ipx, ipx + iea - 8'd1);
                     cy_in = 9'(ipy); vert_in = 1'b0;
                  end
                  REQ_GLYPH: begin
                     // glyphs only ever set pixels
                     color_in = 1'b1;
                     st_in = (9'(ipx) >= 9'(DispWidth)) || (9'(ipy) >= 9'(DispHeight)) ||
                             (icode < GlyphFirst) || (icode > GlyphLast);
                     state_in = st_in ? ST_RESP : ST_NEXT;
                  end
                  REQ_CLEAR, REQ_INVERT: state_in = ST_RD;
                  REQ_READ: begin
                     ca_in = (AddrW+1)'(ibidx);
                     st_in = 32'(ibidx) >= FbBytes;
                     state_in = st_in ? ST_RESP : ST_RD;
                  end
                  default: begin st_in = 1'b1; state_in = ST_RESP; end
               endcase
            end
         end
         ST_NEXT: begin
            // pick next memory op or finish
            if (kind_ff == REQ_GLYPH) begin
               state_in = pix_ok ? ST_RD : ST_NEXT;
               if (!pix_ok) begin
                  if (gr_ff == 3'd6) begin
                     gr_in = 3'd0; gc_in = gc_ff + 3'd1;
                     if (gc_ff == 3'd4) state_in = ST_RESP;
                  end else gr_in = gr_ff + 3'd1;
               end
            end else begin
               logic inrun;
               inrun = vert_ff ? (cy_ff <= lim_ff && cy_ff < 9'(DispHeight))
                               : (cx_ff <= lim_ff && cx_ff < 9'(DispWidth));
               if (inrun) state_in = ST_RD;
               else if (kind_ff == REQ_RECT && edge_ff != 2'd3) begin
                  edge_in = edge_ff + 2'd1;
                  unique case (edge_ff)
                     2'd0: begin
                        {cx_in, lim_in} = hsetup(px_ff, xe_ff); cy_in = 9'(ye_ff);
                        vert_in = 1'b0;
                        if (9'(ye_ff) >= 9'(DispHeight)) cx_in = 9'h100;
                     end
                     2'd1: begin
                        {cy_in, lim_in} = hsetup(py_ff, ye_ff); cx_in = 9'(px_ff);
                        vert_in = 1'b1;
                        if (9'(px_ff) >= 9'(DispWidth)) cy_in = 9'h100;
                     end
                     default: begin
                        {cy_in, lim_in} = hsetup(py_ff, ye_ff); cx_in = 9'(xe_ff);
                        vert_in = 1'b1;
                        if (9'(xe_ff) >= 9'(DispWidth)) cy_in = 9'h100;
                     end
                  endcase
               end else if (kind_ff == REQ_FILL &&
                            cy_ff + 9'd1 < yend_ff && cy_ff + 9'd1 < 9'(DispHeight)) begin
                  // advance to next row; hsetup start re-derived from px/xe
                  cy_in = cy_ff + 9'd1;
                  {cx_in, lim_in} = hsetup(px_ff, xe_ff);
               end else state_in = ST_RESP;
               if (kind_ff == REQ_FILL && cy_ff == 9'(py_ff) &&
                   !(cy_ff < yend_ff && cy_ff < 9'(DispHeight))) state_in = ST_RESP;
            end
         end
         ST_RD: state_in = ST_WR;
         ST_WR: begin
            if (kind_ff == REQ_READ) begin
               rd_in = q_ff; state_in = ST_RESP;
            end else if (kind_ff == REQ_PIXEL) state_in = ST_RESP;
            else if (kind_ff == REQ_CLEAR || kind_ff == REQ_INVERT) begin
               ca_in = ca_ff + 1'b1;
               state_in = (ca_ff == (AddrW+1)'(FbBytes - 1)) ? ST_RESP : ST_RD;
            end else if (kind_ff == REQ_GLYPH) begin
               state_in = ST_NEXT;
               if (gr_ff == 3'd6) begin
                  gr_in = 3'd0; gc_in = gc_ff + 3'd1;
                  if (gc_ff == 3'd4) state_in = ST_RESP;
               end else gr_in = gr_ff + 3'd1;
            end else begin
               if (vert_ff) cy_in = cy_ff + 9'd1; else cx_in = cx_ff + 9'd1;
               state_in = ST_NEXT;
            end
         end
         ST_RESP: begin
            if (!rv_ff) begin rv_in = 1'b1; state_in = ST_IDLE; end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT; ca_ff <= '0; rv_ff <= 1'b0;
      end else begin
         state_ff <= state_in; ca_ff <= ca_in; rv_ff <= rv_in;
      end
      kind_ff <= kind_in; px_ff <= px_in; py_ff <= py_in; xe_ff <= xe_in;
      ye_ff <= ye_in; yend_ff <= yend_in; color_ff <= color_in; gidx_ff <= gidx_in;
      edge_ff <= edge_in; cx_ff <= cx_in; cy_ff <= cy_in; lim_ff <= lim_in;
      vert_ff <= vert_in; gc_ff <= gc_in; gr_ff <= gr_in; rd_ff <= rd_in; st_ff <= st_in;
   end

   // no request taken during the clearing pass
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_INIT) |-> !req_tready) else $error("ready during init");
   // a response is raised only from the response state
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(state_ff) == ST_RESP) else $error("stray response");
   // a read request never writes the store
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WR && kind_ff == REQ_READ) |-> !we) else $error("read wrote");
endmodule

/* dv/tb_mono_framebuffer_draw_engine_unit.sv */
// Testbench for the monochrome framebuffer draw engine: directed table, random requests.
module tb_mono_framebuffer_draw_engine_unit;
   timeunit 1ns;
   timeprecision 1ps;
   import mfde_pkg::*;

   localparam int RandomBeats = 830;
   localparam int CycleLimit  = 100000000;
   localparam logic [3:0] REQ_BAD = 4'd12;

   typedef struct packed {
      logic [3:0] kind;
      logic [7:0] px;
      logic [7:0] py;
      logic [7:0] ea;
      logic [7:0] eb;
      logic       color;
      logic [7:0] code;
      logic [9:0] bidx;
   } draw_req_t;

   typedef struct packed {
      logic [7:0] rdata;
      logic       status;
   } draw_rsp_t;

   // Directed row: request, plus an optional typed-in expected response.
   typedef struct packed {
      draw_req_t req;
      logic      fixed;
      draw_rsp_t rsp;
   } dir_row_t;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [3:0]  req_tuser = '0;
   logic [55:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;

   mono_framebuffer_draw_engine_unit u_top (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tuser(req_tuser), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Shadow framebuffer and pending responses.
   logic [7:0] shadow_fb [FbBytes];
   draw_rsp_t  pending_rsp [$];
   int         mismatches = 0;
   int         rsp_seen = 0;
   int         cycles = 0;
   bit         sink_calm = 1'b0;
   bit         stim_done = 1'b0;
   int         kind_hits [16];

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch at response %0d: %s got %0h want %0h", rsp_seen, what, got, want);
      mismatches++;
   endtask

   function automatic void shadow_px(input int x, input int y, input bit on);
      int a;
      if (x >= DispWidth || y >= DispHeight) return;
      a = (y / 8) * DispWidth + x;
      if (on) shadow_fb[a][y % 8] = 1'b1;
      else shadow_fb[a][y % 8] = 1'b0;
   endfunction

   function automatic bit shadow_hspan(input int a, input int y, input int b, input bit on);
      int t;
      if (a > b) begin
         t = a; a = b; b = t;
      end
      if (y >= DispHeight) return 1'b1;
      for (int x = a; x <= b && x < DispWidth; x++) shadow_px(x, y, on);
      return 1'b0;
   endfunction

   function automatic bit shadow_vspan(input int x, input int a, input int b, input bit on);
      int t;
      if (a > b) begin
         t = a; a = b; b = t;
      end
      if (x >= DispWidth) return 1'b1;
      for (int y = a; y <= b && y < DispHeight; y++) shadow_px(x, y, on);
      return 1'b0;
   endfunction

   // Independent font table: column bytes of each printable code, first column first.
   function automatic logic [7:0] font_col(input int idx, input int col);
      logic [39:0] r;
      case (idx)
         0: r=40'h0000000000; 1: r=40'h00005F0000; 2: r=40'h0007000700;
         3: r=40'h147F147F14; 4: r=40'h242A7F2A12; 5: r=40'h2313086462;
         6: r=40'h3649552250; 7: r=40'h0005030000; 8: r=40'h001C224100;
         9: r=40'h0041221C00; 10: r=40'h14083E0814; 11: r=40'h08083E0808;
         12: r=40'h0050300000; 13: r=40'h0808080808; 14: r=40'h0060600000;
         15: r=40'h2010080402; 16: r=40'h3E5149453E; 17: r=40'h00427F4000;
         18: r=40'h4261514946; 19: r=40'h2141454B31; 20: r=40'h1814127F10;
         21: r=40'h2745454539; 22: r=40'h3C4A494931; 23: r=40'h4121110907;
         24: r=40'h3649494936; 25: r=40'h464949291E; 26: r=40'h0036360000;
         27: r=40'h0056360000; 28: r=40'h0814224100; 29: r=40'h1414141414;
         30: r=40'h0041221408; 31: r=40'h0201510906; 32: r=40'h324959513E;
         33: r=40'h7E1111117E; 34: r=40'h7F49494936; 35: r=40'h3E41414122;
         36: r=40'h7F4141413E; 37: r=40'h7F49494941; 38: r=40'h7F09090901;
         39: r=40'h3E4149497A; 40: r=40'h7F0808087F; 41: r=40'h00417F4100;
         42: r=40'h2040413F01; 43: r=40'h7F08142241; 44: r=40'h7F40404040;
         45: r=40'h7F020C027F; 46: r=40'h7F0408107F; 47: r=40'h3E4141413E;
         48: r=40'h7F09090906; 49: r=40'h3E4151215E; 50: r=40'h7F09192946;
         51: r=40'h4649494931; 52: r=40'h01017F0101; 53: r=40'h3F4040403F;
         54: r=40'h1F2040201F; 55: r=40'h3F4038403F; 56: r=40'h6314081463;
         57: r=40'h0708700807; 58: r=40'h6151494543; 59: r=40'h007F414100;
         60: r=40'h0204081020; 61: r=40'h0041417F00; 62: r=40'h0402010204;
         63: r=40'h4040404040; 64: r=40'h0003070000; 65: r=40'h2054545478;
         66: r=40'h7F48444438; 67: r=40'h3844444420; 68: r=40'h384444487F;
         69: r=40'h3854545418; 70: r=40'h087E090102; 71: r=40'h0C5252523E;
         72: r=40'h7F08040478; 73: r=40'h00447D4000; 74: r=40'h2040443D00;
         75: r=40'h7F10284400; 76: r=40'h00417F4000; 77: r=40'h7C04180478;
         78: r=40'h7C08040478; 79: r=40'h3844444438; 80: r=40'h7C14141408;
         81: r=40'h081414187C; 82: r=40'h7C08040408; 83: r=40'h4854545420;
         84: r=40'h043F444020; 85: r=40'h3C4040207C; 86: r=40'h1C2040201C;
         87: r=40'h3C4030403C; 88: r=40'h4428102844; 89: r=40'h0C5050503C;
         90: r=40'h4464544C44; 91: r=40'h0008364100; 92: r=40'h00007F0000;
         93: r=40'h0041360800; 94: r=40'h1008080810;
         default: r = 40'h0;
      endcase
      return r[39 - 8*col -: 8];
   endfunction

   // Apply one request to the shadow buffer and return the response it should give.
   function automatic draw_rsp_t draw_and_predict(input draw_req_t r);
      draw_rsp_t o;
      int xe, ye;
      logic [7:0] bits;
      o = '0;
      xe = (int'(r.px) + int'(r.ea) - 1) & 8'hFF;
      ye = (int'(r.py) + int'(r.eb) - 1) & 8'hFF;
      case (r.kind)
         REQ_PIXEL: begin
            if (r.px >= DispWidth || r.py >= DispHeight) o.status = 1'b1;
            else shadow_px(int'(r.px), int'(r.py), r.color);
         end
         REQ_HSPAN: o.status = shadow_hspan(int'(r.px), int'(r.py), int'(r.ea), r.color);
         REQ_VSPAN: o.status = shadow_vspan(int'(r.px), int'(r.py), int'(r.eb), r.color);
         REQ_RECT: begin
            void'(shadow_hspan(int'(r.px), int'(r.py), xe, r.color));
            void'(shadow_hspan(int'(r.px), ye, xe, r.color));
            void'(shadow_vspan(int'(r.px), int'(r.py), ye, r.color));
            void'(shadow_vspan(xe, int'(r.py), ye, r.color));
         end
         REQ_FILL: begin
            for (int i = int'(r.py); i < int'(r.py) + int'(r.eb) && i < DispHeight; i++)
               void'(shadow_hspan(int'(r.px), i, xe, r.color));
         end
         REQ_GLYPH: begin
            if (r.px >= DispWidth || r.py >= DispHeight ||
                r.code < GlyphFirst || r.code > GlyphLast) begin
               o.status = 1'b1;
            end else begin
               for (int c = 0; c < 5; c++) begin
                  bits = font_col(int'(r.code) - int'(GlyphFirst), c);
                  for (int w = 0; w < 7; w++)
                     if (bits[w]) shadow_px(int'(r.px) + c, int'(r.py) + w, 1'b1);
               end
            end
         end
         REQ_CLEAR: foreach (shadow_fb[i]) shadow_fb[i] = '0;
         REQ_INVERT: foreach (shadow_fb[i]) shadow_fb[i] = ~shadow_fb[i];
         REQ_READ: begin
            if (r.bidx < FbBytes) o.rdata = shadow_fb[r.bidx];
            else o.status = 1'b1;
         end
         default: o.status = 1'b1;
      endcase
      return o;
   endfunction

   function automatic draw_req_t mk(input logic [3:0] k, input int x, input int y,
                                    input int a, input int b, input bit c,
                                    input int code, input int bi);
      draw_req_t r;
      r.kind = k; r.px = 8'(x); r.py = 8'(y); r.ea = 8'(a); r.eb = 8'(b);
      r.color = c; r.code = 8'(code); r.bidx = 10'(bi);
      return r;
   endfunction

   // Random request; mostly on-screen geometry with small extents, some wild values.
   function automatic draw_req_t rand_req();
      draw_req_t r;
      int p;
      r = mk(4'(0), 0, 0, 0, 0, 1'($urandom), int'($urandom), int'($urandom));
      p = $urandom_range(0, 99);
      if (p < 14) r.kind = REQ_PIXEL;
      else if (p < 26) r.kind = REQ_HSPAN;
      else if (p < 38) r.kind = REQ_VSPAN;
      else if (p < 48) r.kind = REQ_RECT;
      else if (p < 56) r.kind = REQ_FILL;
      else if (p < 68) r.kind = REQ_GLYPH;
      else if (p < 70) r.kind = REQ_CLEAR;
      else if (p < 72) r.kind = REQ_INVERT;
      else if (p < 96) r.kind = REQ_READ;
      else r.kind = 4'($urandom_range(9, 15));
      if ($urandom_range(0, 9) < 8) begin
         r.px = 8'($urandom_range(0, DispWidth - 1));
         r.py = 8'($urandom_range(0, DispHeight - 1));
         r.ea = (r.kind == REQ_HSPAN) ? 8'($urandom_range(0, DispWidth - 1))
                                      : 8'($urandom_range(0, 20));
         r.eb = (r.kind == REQ_VSPAN) ? 8'($urandom_range(0, DispHeight - 1))
                                      : 8'($urandom_range(0, 12));
         r.code = 8'($urandom_range(30, 128));
         r.bidx = 10'($urandom_range(0, FbBytes - 1));
      end else begin
         r.px = 8'($urandom); r.py = 8'($urandom); r.ea = 8'($urandom);
         r.eb = 8'($urandom); r.bidx = 10'($urandom);
      end
      // keep fills small so the run stays short
      if (r.kind == REQ_FILL && r.ea > 24) r.ea = 8'($urandom_range(0, 24));
      return r;
   endfunction

   // Drive one beat on the request side; predict at acceptance.
   task automatic send_req(input draw_req_t r, input bit fixed, input draw_rsp_t want,
                           input bit allow_gaps);
      draw_rsp_t got;
      if (allow_gaps && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= r.kind;
      req_tdata  <= {5'b0, r.bidx, r.code, r.color, r.eb, r.ea, r.py, r.px};
      do @(posedge clock); while (!req_tready);
      got = draw_and_predict(r);
      if (fixed && got != want) begin
         report_mismatch("table entry", int'(got), int'(want));
      end
      pending_rsp.push_back(fixed ? want : got);
      kind_hits[r.kind]++;
      @(negedge clock);
   endtask

   // Response side: random stall bursts, compare against the oldest expectation.
   initial begin : rsp_side
      draw_rsp_t want;
      forever begin
         @(negedge clock);
         if (!sink_calm && $urandom_range(0, 3) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) begin
            rsp_seen++;
            if (pending_rsp.size() == 0) begin
               report_mismatch("unexpected response", int'(rsp_tdata), 0);
            end else begin
               want = pending_rsp.pop_front();
               if (rsp_tdata[7:0] != want.rdata)
                  report_mismatch("read_data", int'(rsp_tdata[7:0]), int'(want.rdata));
               if (rsp_tdata[8] != want.status)
                  report_mismatch("status", int'(rsp_tdata[8]), int'(want.status));
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CycleLimit) begin
         $display("timeout after %0d cycles", cycles);
         $display("FAILED: results differ");
         $finish;
      end
   end

   dir_row_t dir_rows [$];

   initial begin : stim
      draw_req_t r;
      foreach (shadow_fb[i]) shadow_fb[i] = '0;
      // Directed table: extremes, every request, the named corner cases.
      dir_rows = '{
         '{mk(REQ_READ, 0, 0, 0, 0, 0, 0, 0), 1'b1, '{8'h00, 1'b0}},
         '{mk(REQ_READ, 0, 0, 0, 0, 0, 0, FbBytes - 1), 1'b1, '{8'h00, 1'b0}},
         '{mk(REQ_READ, 0, 0, 0, 0, 0, 0, 1023), 1'b1, '{8'h00, 1'b0}},
         '{mk(REQ_PIXEL, 0, 0, 0, 0, 1, 0, 0), 1'b1, '{8'h00, 1'b0}},
         '{mk(REQ_READ, 0, 0, 0, 0, 0, 0, 0), 1'b1, '{8'h01, 1'b0}},
         '{mk(REQ_PIXEL, 255, 255, 0, 0, 1, 0, 0), 1'b1, '{8'h00, 1'b1}},
         '{mk(REQ_PIXEL, 127, 63, 0, 0, 1, 0, 0), 1'b1, '{8'h00, 1'b0}},
         '{mk(REQ_READ, 0, 0, 0, 0, 0, 0, 1023), 1'b1, '{8'h80, 1'b0}},
         '{mk(REQ_HSPAN, 200, 5, 100, 0, 1, 0, 0), 1'b0, '0},
         '{mk(REQ_HSPAN, 0, 64, 10, 0, 1, 0, 0), 1'b1, '{8'h00, 1'b1}},
         '{mk(REQ_VSPAN, 3, 200, 0, 10, 1, 0, 0), 1'b0, '0},
         '{mk(REQ_VSPAN, 128, 0, 0, 10, 1, 0, 0), 1'b1, '{8'h00, 1'b1}},
         '{mk(REQ_RECT, 10, 10, 0, 0, 1, 0, 0), 1'b0, '0},
         '{mk(REQ_RECT, 120, 60, 255, 255, 1, 0, 0), 1'b0, '0},
         '{mk(REQ_FILL, 100, 50, 40, 255, 1, 0, 0), 1'b0, '0},
         '{mk(REQ_FILL, 20, 20, 8, 6, 0, 0, 0), 1'b0, '0},
         '{mk(REQ_GLYPH, 125, 60, 0, 0, 0, 65, 0), 1'b0, '0},
         '{mk(REQ_GLYPH, 0, 0, 0, 0, 0, 126, 0), 1'b0, '0},
         '{mk(REQ_GLYPH, 0, 0, 0, 0, 1, 31, 0), 1'b1, '{8'h00, 1'b1}},
         '{mk(REQ_GLYPH, 0, 0, 0, 0, 1, 127, 0), 1'b1, '{8'h00, 1'b1}},
         '{mk(REQ_GLYPH, 128, 0, 0, 0, 1, 65, 0), 1'b1, '{8'h00, 1'b1}},
         '{mk(REQ_INVERT, 0, 0, 0, 0, 0, 0, 0), 1'b1, '{8'h00, 1'b0}},
         '{mk(REQ_READ, 0, 0, 0, 0, 0, 0, 0), 1'b1, '{8'hEE, 1'b0}},
         '{mk(REQ_BAD, 255, 255, 255, 255, 1, 255, 1023), 1'b1, '{8'h00, 1'b1}},
         '{mk(REQ_CLEAR, 0, 0, 0, 0, 0, 0, 0), 1'b1, '{8'h00, 1'b0}}
      };
      // Hold reset, then release it once.
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      foreach (dir_rows[i]) send_req(dir_rows[i].req, dir_rows[i].fixed, dir_rows[i].rsp, 1'b1);
      for (int n = 0; n < RandomBeats; n++) begin
         // Drain everything once midway.
         if (n == RandomBeats / 2) begin
            req_tvalid <= 1'b0;
            wait (pending_rsp.size() == 0);
            @(negedge clock);
         end
         // Last stretch runs without gaps on either side.
         if (n == RandomBeats - 60) sink_calm = 1'b1;
         r = rand_req();
         send_req(r, 1'b0, '0, n < RandomBeats - 60);
      end
      req_tvalid <= 1'b0;
      wait (pending_rsp.size() == 0);
      repeat (2200) @(posedge clock);
      $display("covered %0d responses: pixel %0d hspan %0d vspan %0d rect %0d fill %0d",
               rsp_seen, kind_hits[REQ_PIXEL], kind_hits[REQ_HSPAN], kind_hits[REQ_VSPAN],
               kind_hits[REQ_RECT], kind_hits[REQ_FILL]);
      $display("glyph %0d clear %0d invert %0d read %0d, plus unknown codes",
               kind_hits[REQ_GLYPH], kind_hits[REQ_CLEAR], kind_hits[REQ_INVERT],
               kind_hits[REQ_READ]);
      if (mismatches == 0 && pending_rsp.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end
endmodule
